/* hw/rtl/mppm_pkg.sv */
// Shared types, register codes and defaults of the multi-pattern packet matcher.
package mppm_pkg;

  localparam int SLOT_REGS           = 4;
  localparam int NUM_PATTERNS_DEF    = 4;
  localparam int MAX_PATTERN_LEN_DEF = 8;

  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;
  localparam int LEN_FIELD_W = 4;
  localparam int LENS_W      = 16;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int SLOT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd5;

  typedef struct packed {
    logic [SLOT_REGS-1:0][PAT_W-1:0] pattern_bytes;
    logic [LENS_W-1:0]               pattern_lengths;
    logic [COUNT_W-1:0]              pattern_count;
  } cfg_t;

endpackage

/* hw/rtl/mppm_cfg_regs.sv */
// Configuration register file of the packet matcher, written through a plain write port.
module mppm_cfg_regs
  import mppm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAT_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_BYTES_0: cfg_d.pattern_bytes[0] = cfg_wdata_i;
        REG_PATTERN_BYTES_1: cfg_d.pattern_bytes[1] = cfg_wdata_i;
        REG_PATTERN_BYTES_2: cfg_d.pattern_bytes[2] = cfg_wdata_i;
        REG_PATTERN_BYTES_3: cfg_d.pattern_bytes[3] = cfg_wdata_i;
        REG_PATTERN_LENGTHS: cfg_d.pattern_lengths = cfg_wdata_i[LENS_W-1:0];
        REG_PATTERN_COUNT:   cfg_d.pattern_count = cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/mppm_slot_cmp.sv */
// Compares one pattern slot against the window of the newest packet bytes.
module mppm_slot_cmp
  import mppm_pkg::*;
#(
  parameter int MaxLen = MAX_PATTERN_LEN_DEF,
  parameter int AvailW = $clog2(MaxLen + 1)
) (
  input  logic [PAT_W-1:0]         pat_i,
  input  logic [LEN_FIELD_W-1:0]   len_i,
  input  logic [MaxLen*BYTE_W-1:0] window_i,
  input  logic [AvailW-1:0]        avail_i,
  output logic                     hit_o
);

  always_comb begin
    logic [LEN_FIELD_W-1:0] len;
    logic                   ok;
    len = (len_i > LEN_FIELD_W'(MaxLen)) ? LEN_FIELD_W'(MaxLen) : len_i;
    hit_o = (len == '0);
    // The first pattern byte lines up with the oldest byte of the window in use.
    for (int l = 1; l <= MaxLen; l++) begin
      ok = (len == LEN_FIELD_W'(l)) && (avail_i >= AvailW'(l));
      for (int i = 0; i < l; i++) begin
        ok = ok && (pat_i[BYTE_W*i +: BYTE_W] == window_i[BYTE_W*(l-1-i) +: BYTE_W]);
      end
      hit_o = hit_o || ok;
    end
  end

endmodule

/* hw/rtl/multi_pattern_packet_matcher.sv */
// Top level of the multi-pattern packet matcher: input register, match stage, result register.
//
// The block takes one packet byte per cycle and searches it, together with the preceding
// bytes of the same packet, against every active pattern slot at once; all slot compares
// run in parallel in the match stage, so the sustained rate is one item per cycle while no
// last byte waits for the result register. A result is registered only for the last byte
// of a packet, as that byte leaves the input register, and reports the lowest-numbered slot
// that matched anywhere in the packet. Bytes that are not last keep flowing while a result
// waits at the output; a last byte waits in the input register until the result register
// is free. Configuration must be written while no packet byte is in flight.
module multi_pattern_packet_matcher
  import mppm_pkg::*;
#(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [0] match_found, [2:1] pattern_slot
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAT_W-1:0]     cfg_wdata_i
);

  localparam int NumSlots = (NUM_PATTERNS < SLOT_REGS) ? NUM_PATTERNS : SLOT_REGS;
  localparam int WinW     = MAX_PATTERN_LEN * BYTE_W;
  localparam int HistW    = (MAX_PATTERN_LEN > 1) ? (MAX_PATTERN_LEN - 1) * BYTE_W : BYTE_W;
  localparam int CntW     = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int AvailW   = $clog2(MAX_PATTERN_LEN + 1);

  cfg_t cfg;

  mppm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register.
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              advance;
  logic              accept;

  // Per-packet match state.
  logic [HistW-1:0]    hist_q, hist_d;
  logic [CntW-1:0]     seen_q, seen_d;
  logic [NumSlots-1:0] found_q, found_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_match_q, out_match_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic [HistW+BYTE_W-1:0] window_full;
  logic [WinW-1:0]         window;
  logic [AvailW-1:0]       avail;
  logic [NumSlots-1:0]     hits;
  logic [NumSlots-1:0]     slot_en;

  // A byte that closes a packet needs the result register; other bytes always move on.
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_valid_d = accept || (in_valid_q && !advance);

  assign window_full = {hist_q, in_byte_q};
  assign window = window_full[WinW-1:0];
  assign avail = AvailW'(seen_q) + AvailW'(1);

  for (genvar s = 0; s < NumSlots; s++) begin : g_slot
    assign slot_en[s] = (cfg.pattern_count > COUNT_W'(s));
    mppm_slot_cmp #(
      .MaxLen (MAX_PATTERN_LEN),
      .AvailW (AvailW)
    ) u_slot_cmp (
      .pat_i    (cfg.pattern_bytes[s]),
      .len_i    (cfg.pattern_lengths[LEN_FIELD_W*s +: LEN_FIELD_W]),
      .window_i (window),
      .avail_i  (avail),
      .hit_o    (hits[s])
    );
  end

  always_comb begin
    logic [NumSlots-1:0] found_now;
    found_now   = found_q | (hits & slot_en);
    hist_d      = hist_q;
    seen_d      = seen_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_match_d = out_match_q;
    out_slot_d  = out_slot_q;
    if (advance) begin
      if (in_last_q) begin
        hist_d      = '0;
        seen_d      = '0;
        found_d     = '0;
        out_valid_d = 1'b1;
        out_match_d = |found_now;
        out_slot_d  = '0;
        for (int s = NumSlots - 1; s >= 0; s--) begin
          if (found_now[s]) begin
            out_slot_d = SLOT_W'(s);
          end
        end
      end else begin
        hist_d  = window_full[HistW-1:0];
        found_d = found_now;
        if (seen_q < CntW'(MAX_PATTERN_LEN - 1)) begin
          seen_d = seen_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      hist_q      <= '0;
      seen_q      <= '0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      hist_q      <= hist_d;
      seen_q      <= seen_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    out_match_q <= out_match_d;
    out_slot_q  <= out_slot_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_slot_q, out_match_q};

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_last_q))
    else $error("result appeared without a closing byte");

  a_seen_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntW'(MAX_PATTERN_LEN - 1))
    else $error("byte count ran past the window");

  a_slot_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_match_q) |-> (out_slot_q == '0))
    else $error("slot set on a packet without a match");

  a_clear_after_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (seen_q == '0 && found_q == '0 && hist_q == '0))
    else $error("packet state not cleared after the last byte");

endmodule

/* bench/tb_multi_pattern_packet_matcher.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the multi-pattern packet matcher.
module tb_multi_pattern_packet_matcher;
  import mppm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int HIST_W       = (MAX_PATTERN_LEN_DEF - 1) * BYTE_W;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 58;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } verdict_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [PAT_W-1:0]     cfg_wdata_i   = '0;

  multi_pattern_packet_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the matcher registers and its per-packet state.
  logic [PAT_W-1:0]     pat_bytes [SLOT_REGS] = '{default: '0};
  logic [LENS_W-1:0]    pat_lens   = '0;
  logic [COUNT_W-1:0]   pat_count  = '0;
  logic [HIST_W-1:0]    hist_bytes = '0;
  int                   hist_fill  = 0;
  logic [SLOT_REGS-1:0] hit_mask   = '0;

  pkt_byte_t byte_q [$];
  verdict_t  verdict_q [$];
  pkt_byte_t cur_byte = '0;
  bit        in_hand  = 1'b0;
  int        gap_left = 0;

  bit src_idle_on = 1'b0;
  bit snk_idle_on = 1'b0;
  bit hold_armed  = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;
  bit narrow      = 1'b0;

  int errors         = 0;
  int items_queued   = 0;
  int bytes_sent     = 0;
  int verdicts_seen  = 0;
  int settings_used  = 0;
  int slot_matches [SLOT_REGS] = '{default: 0};

  initial forever #5 clk_i = ~clk_i;

  function automatic int eff_len(input int s);
    int l;
    l = pat_lens[LEN_FIELD_W*s +: LEN_FIELD_W];
    return (l > MAX_PATTERN_LEN_DEF) ? MAX_PATTERN_LEN_DEF : l;
  endfunction

  // Advances the shadow state by one packet byte; a last byte yields the verdict.
  task automatic scan_byte(input pkt_byte_t b, output bit has_res, output verdict_t v);
    logic [PAT_W-1:0] win;
    int avail, active, len, s, i;
    bit hit;
    win    = {hist_bytes, b.data};
    avail  = hist_fill + 1;
    active = pat_count;
    if (active > NUM_PATTERNS_DEF) active = NUM_PATTERNS_DEF;
    if (active > SLOT_REGS) active = SLOT_REGS;
    for (s = 0; s < active; s++) begin
      len = eff_len(s);
      hit = (avail >= len);
      // Pattern byte 0 lines up with the oldest byte of the window.
      for (i = 0; i < len; i++)
        if (pat_bytes[s][BYTE_W*i +: BYTE_W] != win[BYTE_W*(len-1-i) +: BYTE_W]) hit = 1'b0;
      if (hit) hit_mask[s] = 1'b1;
    end
    v       = '0;
    has_res = b.last;
    if (!b.last) begin
      hist_bytes = win[HIST_W-1:0];
      if (hist_fill < MAX_PATTERN_LEN_DEF - 1) hist_fill++;
    end else begin
      for (s = SLOT_REGS - 1; s >= 0; s--)
        if (hit_mask[s]) begin
          v.found = 1'b1;
          v.slot  = SLOT_W'(s);
        end
      hist_bytes = '0;
      hist_fill  = 0;
      hit_mask   = '0;
    end
  endtask

  function automatic logic [PAT_W-1:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    if (narrow)
      case ($urandom_range(0, 3))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'h5A;
        default: b = 8'hA5;
      endcase
    return b;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l);
    byte_q.push_back('{data: d, last: l});
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_PATTERN_BYTES_0: pat_bytes[0] = data;
      REG_PATTERN_BYTES_1: pat_bytes[1] = data;
      REG_PATTERN_BYTES_2: pat_bytes[2] = data;
      REG_PATTERN_BYTES_3: pat_bytes[3] = data;
      REG_PATTERN_LENGTHS: pat_lens = data[LENS_W-1:0];
      REG_PATTERN_COUNT:   pat_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Random packet, usually carrying a copy of one slot's pattern that is sometimes damaged.
  task automatic add_packet(input int span, input bit close);
    logic [BYTE_W-1:0] body [$];
    int s, n, pos, i, k;
    for (i = 0; i < span; i++) body.push_back(pick_byte());
    if ($urandom_range(0, 2) != 0) begin
      s = $urandom_range(0, SLOT_REGS - 1);
      n = eff_len(s);
      if (n > 0 && $urandom_range(0, 4) == 0) n--;
      while (body.size() < n) body.push_back(pick_byte());
      pos = $urandom_range(0, body.size() - n);
      for (i = 0; i < n; i++) body[pos+i] = pat_bytes[s][BYTE_W*i +: BYTE_W];
      if (n > 0 && $urandom_range(0, 5) == 0) begin
        k = pos + $urandom_range(0, n - 1);
        body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (i = 0; i < body.size(); i++) push_byte(body[i], close && (i == body.size() - 1));
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (byte_q.size() != 0 || in_hand || verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : byte_driver
    bit       has_res;
    verdict_t v;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(cur_byte, has_res, v);
        if (has_res) verdict_q.push_back(v);
        in_hand = 1'b0;
        bytes_sent++;
      end
      if (!in_hand) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0) begin
          if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 6);
          end else begin
            cur_byte = byte_q.pop_front();
            in_hand  = 1'b1;
          end
        end
      end
      s_axis_tvalid <= in_hand;
      s_axis_tdata  <= cur_byte.data;
      s_axis_tlast  <= cur_byte.last;
    end
  end

  always @(posedge clk_i) begin : verdict_monitor
    verdict_t exp;
    bit       nxt_ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict: none expected, got tdata %h", m_axis_tdata);
          errors++;
        end else begin
          exp = verdict_q.pop_front();
          verdicts_seen++;
          if (exp.found) slot_matches[exp.slot]++;
          if (m_axis_tdata[0] !== exp.found) begin
            $error("match_found: expected %0d, got %0d", exp.found, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[2:1] !== exp.slot) begin
            $error("pattern_slot: expected %0d, got %0d", exp.slot, m_axis_tdata[2:1]);
            errors++;
          end
          if (m_axis_tdata[7:3] !== 5'd0) begin
            $error("tdata padding: expected 0, got %0d", m_axis_tdata[7:3]);
            errors++;
          end
        end
      end
      // A single long hold lets results back up until the input side stalls.
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        nxt_ready = 1'b0;
      end else if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  initial begin : stimulus
    int p, s, k, c, start_n;
    logic [PAT_W-1:0]  word;
    logic [LENS_W-1:0] lens;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed setting: full-length all-ones pattern, a two-byte pattern, an over-long
    // length that clips to eight, a zero-length pattern and a count above the slots.
    write_reg(REG_PATTERN_BYTES_0, '1);
    write_reg(REG_PATTERN_BYTES_1, 64'h0201);
    write_reg(REG_PATTERN_BYTES_2, '0);
    write_reg(REG_PATTERN_BYTES_3, 64'hDEAD_BEEF_0000_00A5);
    word = rand64();
    word[LENS_W-1:0] = 16'h0F28;
    write_reg(REG_PATTERN_LENGTHS, word);
    write_reg(REG_PATTERN_COUNT, '1);
    write_reg(REG_SPARE_6, rand64());
    settings_used++;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    push_byte(8'h00, 1'b1);
    for (k = 0; k < 8; k++) push_byte(8'hFF, k == 7);
    for (k = 0; k < 7; k++) push_byte(8'hFF, k == 6);
    // The two-byte pattern split over two packets must not match.
    push_byte(8'h01, 1'b1);
    push_byte(8'h02, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      narrow = $urandom_range(0, 1);
      for (s = 0; s < SLOT_REGS; s++) begin
        if (p == 1) begin
          word = (s % 2 == 0) ? '1 : '0;
        end else begin
          for (k = 0; k < 8; k++) word[BYTE_W*k +: BYTE_W] = pick_byte();
        end
        case (s)
          0:       write_reg(REG_PATTERN_BYTES_0, word);
          1:       write_reg(REG_PATTERN_BYTES_1, word);
          2:       write_reg(REG_PATTERN_BYTES_2, word);
          default: write_reg(REG_PATTERN_BYTES_3, word);
        endcase
      end
      for (s = 0; s < SLOT_REGS; s++) begin
        if (p == 0) c = 0;
        else if (p == 1) c = 15;
        else if ($urandom_range(0, 4) == 0) c = $urandom_range(9, 15);
        else c = $urandom_range(0, 8);
        lens[LEN_FIELD_W*s +: LEN_FIELD_W] = LEN_FIELD_W'(c);
      end
      word = rand64();
      word[LENS_W-1:0] = lens;
      write_reg(REG_PATTERN_LENGTHS, word);
      if (p == 0) c = 0;
      else if (p == 1) c = 4;
      else if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 7);
      else c = $urandom_range(1, 4);
      word = rand64();
      word[COUNT_W-1:0] = COUNT_W'(c);
      write_reg(REG_PATTERN_COUNT, word);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, rand64());
      settings_used++;

      src_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      snk_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 3) hold_armed = 1'b1;
      start_n = items_queued;
      while (items_queued - start_n < PHASE_ITEMS) begin
        if (p == 3) c = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0) c = $urandom_range(20, 40);
        else c = $urandom_range(1, 10);
        add_packet(c, 1'b1);
      end
      // Leave a packet open so that the next setting takes over in the middle of it.
      if (p == 5) add_packet($urandom_range(3, 6), 1'b0);
      wait_idle();
    end

    $display("Sent %0d packet bytes under %0d pattern settings; %0d verdicts checked.",
             bytes_sent, settings_used, verdicts_seen);
    $display("Matches by slot: %0d %0d %0d %0d (long output hold and mid-packet change included).",
             slot_matches[0], slot_matches[1], slot_matches[2], slot_matches[3]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
